// ----- sv/spq_pkg.sv -----
// Shared types, sizes and codes of the stable priority queue.
// Self-contained; used by stable_priority_queue and spq_checker.
`default_nettype none

package spq_pkg;

   // Sizes of the queue.
   localparam int NUM_LEVELS  = 16;
   localparam int LEVEL_DEPTH = 16;
   localparam int TAG_BITS    = 16;

   // Widths of the transaction fields.
   localparam int OP_W   = 1;
   localparam int PRIO_W = 4;
   localparam int TAG_W  = 16;
   localparam int STAT_W = 2;

   // Derived widths.
   localparam int LVL_BITS   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int SLOT_BITS  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(LEVEL_DEPTH + 1);
   localparam int MEM_DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_BITS  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD    = 1'b0;
   localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_ADDED   = 2'd0;
   localparam logic [STAT_W-1:0] ST_REMOVED = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PRIO_W-1:0] priority_req;
      logic [TAG_W-1:0]  file_tag;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TAG_W-1:0]  out_tag;
      logic [PRIO_W-1:0] out_priority;
   } rsp_type;

   // Circular slot advance within one level.
   function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] s);
      logic [SLOT_BITS-1:0] r;
      if (s == SLOT_BITS'(LEVEL_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/stable_priority_queue.sv -----
// Top level of the stable priority queue: sequencer, per-level FIFO pointers
// and the tag memory. Depends on spq_pkg.
//
//   Channel | Direction | Handshake              | Payload
//   req_    | in        | req_valid / req_ready  | spq_pkg::req_type
//   rsp_    | out       | rsp_valid / rsp_ready  | spq_pkg::rsp_type
//
// One transaction is handled at a time; req_ready is high only while idle.
// An add goes from S_ACCESS to S_RESP after acceptance. A remove first scans
// the level counts from the highest level down, one level per cycle through a
// single compare, then passes through S_ACCESS and S_READ to S_RESP.
// When every level is empty the scan answers directly, going to S_RESP.
// The tag memory has one port, read data registered. Reset empties all levels
// at once; the memory needs no clearing. A stalled response holds its value.
`default_nettype none

module stable_priority_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output spq_pkg::rsp_type      rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_ACCESS = 5'b00100,
      S_READ   = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [spq_pkg::SLOT_BITS-1:0] head_ff  [spq_pkg::NUM_LEVELS];
   logic [spq_pkg::SLOT_BITS-1:0] head_in  [spq_pkg::NUM_LEVELS];
   logic [spq_pkg::SLOT_BITS-1:0] tail_ff  [spq_pkg::NUM_LEVELS];
   logic [spq_pkg::SLOT_BITS-1:0] tail_in  [spq_pkg::NUM_LEVELS];
   logic [spq_pkg::CNT_BITS-1:0]  count_ff [spq_pkg::NUM_LEVELS];
   logic [spq_pkg::CNT_BITS-1:0]  count_in [spq_pkg::NUM_LEVELS];

   logic [spq_pkg::OP_W-1:0]       op_ff, op_in;
   logic [spq_pkg::LVL_BITS-1:0]   level_ff, level_in;
   logic [spq_pkg::LVL_BITS-1:0]   scan_ff, scan_in;
   logic [spq_pkg::STORE_BITS-1:0] tag_ff, tag_in;
   spq_pkg::rsp_type               rsp_ff, rsp_in;

   logic [spq_pkg::STORE_BITS-1:0] mem [spq_pkg::MEM_DEPTH];
   logic [spq_pkg::STORE_BITS-1:0] rdata_ff;
   logic [spq_pkg::ADDR_BITS-1:0]  mem_addr;
   logic [spq_pkg::SLOT_BITS-1:0]  slot;
   logic                           mem_we;
   logic [spq_pkg::LVL_BITS-1:0]   level_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // Levels above the top one fold onto the top one.
   assign level_sat = (32'(req_data.priority_req) >= spq_pkg::NUM_LEVELS) ?
                      spq_pkg::LVL_BITS'(spq_pkg::NUM_LEVELS - 1) :
                      spq_pkg::LVL_BITS'(req_data.priority_req);

   assign slot     = (op_ff == spq_pkg::OP_ADD) ? tail_ff[level_ff] : head_ff[level_ff];
   assign mem_addr = spq_pkg::ADDR_BITS'(level_ff) *
                     spq_pkg::ADDR_BITS'(spq_pkg::LEVEL_DEPTH) +
                     spq_pkg::ADDR_BITS'(slot);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      level_in = level_ff;
      scan_in  = scan_ff;
      tag_in   = tag_ff;
      rsp_in   = rsp_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      mem_we   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.op;
               level_in = level_sat;
               tag_in   = req_data.file_tag[spq_pkg::STORE_BITS-1:0];
               scan_in  = spq_pkg::LVL_BITS'(spq_pkg::NUM_LEVELS - 1);
               state_in = (req_data.op == spq_pkg::OP_ADD) ? S_ACCESS : S_SCAN;
            end
         end
         S_SCAN: begin
            if (count_ff[scan_ff] != '0) begin
               level_in = scan_ff;
               state_in = S_ACCESS;
            end else if (scan_ff == '0) begin
               rsp_in.status       = spq_pkg::ST_EMPTY;
               rsp_in.out_tag      = '0;
               rsp_in.out_priority = '0;
               state_in            = S_RESP;
            end else begin
               scan_in = scan_ff - 1'b1;
            end
         end
         S_ACCESS: begin
            if (op_ff == spq_pkg::OP_ADD) begin
               rsp_in.out_tag      = '0;
               rsp_in.out_priority = '0;
               if (count_ff[level_ff] == spq_pkg::CNT_BITS'(spq_pkg::LEVEL_DEPTH)) begin
                  rsp_in.status = spq_pkg::ST_FULL;
               end else begin
                  mem_we             = 1'b1;
                  tail_in[level_ff]  = spq_pkg::next_slot(tail_ff[level_ff]);
                  count_in[level_ff] = count_ff[level_ff] + 1'b1;
                  rsp_in.status      = spq_pkg::ST_ADDED;
               end
               state_in = S_RESP;
            end else begin
               // The memory read of the head slot is registered this cycle.
               head_in[level_ff]  = spq_pkg::next_slot(head_ff[level_ff]);
               count_in[level_ff] = count_ff[level_ff] - 1'b1;
               state_in           = S_READ;
            end
         end
         S_READ: begin
            rsp_in.status       = spq_pkg::ST_REMOVED;
            rsp_in.out_tag      = spq_pkg::TAG_W'(rdata_ff);
            rsp_in.out_priority = spq_pkg::PRIO_W'(level_ff);
            state_in            = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      level_ff <= level_in;
      scan_ff  <= scan_in;
      tag_ff   <= tag_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= tag_ff;
      end
      rdata_ff <= mem[mem_addr];
   end

endmodule

`default_nettype wire

// ----- sv/spq_checker.sv -----
// Port-level checks of stable_priority_queue, attached by the bind below.
// Depends on spq_pkg and on the top level's ports.
`default_nettype none

module spq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire spq_pkg::rsp_type rsp_data
);

   // The queue holds one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   // No response can follow acceptance in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("response appeared one cycle after a request");

   // Exactly one response per transaction.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("response repeated after acceptance");

   // Only a removal carries a tag or a level.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != spq_pkg::ST_REMOVED) |->
         (rsp_data.out_tag == '0 && rsp_data.out_priority == '0))
      else $error("nonzero tag or level without a removal");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response dropped or changed");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- bench/tb_stable_priority_queue.sv -----
// Self-checking testbench for stable_priority_queue: directed and random add/remove traffic.
// Depends on spq_pkg for the transaction types, sizes and codes.
// It checks every response against a scoreboard that tracks the per-level FIFO contents.
`timescale 1ns / 1ps

module tb_stable_priority_queue;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 3 + spq_pkg::NUM_LEVELS + 10;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CALM_ITEMS   = 200;

   // Tracks the contents of every level and the response that each request should give.
   class spq_scoreboard;
      logic [spq_pkg::TAG_W-1:0] slot_tag [spq_pkg::NUM_LEVELS][spq_pkg::LEVEL_DEPTH];
      int unsigned head_slot [spq_pkg::NUM_LEVELS];
      int unsigned tail_slot [spq_pkg::NUM_LEVELS];
      int unsigned held [spq_pkg::NUM_LEVELS];
      spq_pkg::rsp_type awaited_rsp [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned status_hits [4];

      function new();
         for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
            head_slot[i] = 0;
            tail_slot[i] = 0;
            held[i] = 0;
         end
         for (int i = 0; i < 4; i++) begin
            status_hits[i] = 0;
         end
         mismatches = 0;
         checked = 0;
      endfunction

      function void note_request(spq_pkg::req_type r);
         spq_pkg::rsp_type e;
         int unsigned      lvl;
         bit               found;
         e = '0;
         found = 0;
         lvl = 0;
         if (r.op == spq_pkg::OP_ADD) begin
            lvl = (r.priority_req >= spq_pkg::NUM_LEVELS) ?
                  spq_pkg::NUM_LEVELS - 1 : r.priority_req;
            if (held[lvl] >= spq_pkg::LEVEL_DEPTH) begin
               e.status = spq_pkg::ST_FULL;
            end else begin
               slot_tag[lvl][tail_slot[lvl]] =
                  spq_pkg::TAG_W'(r.file_tag[spq_pkg::STORE_BITS-1:0]);
               tail_slot[lvl] = (tail_slot[lvl] + 1) % spq_pkg::LEVEL_DEPTH;
               held[lvl]++;
               e.status = spq_pkg::ST_ADDED;
            end
         end else begin
            for (int i = spq_pkg::NUM_LEVELS - 1; i >= 0 && !found; i--) begin
               if (held[i] != 0) begin
                  lvl = i;
                  found = 1;
               end
            end
            if (!found) begin
               e.status = spq_pkg::ST_EMPTY;
            end else begin
               e.status = spq_pkg::ST_REMOVED;
               e.out_tag = slot_tag[lvl][head_slot[lvl]];
               e.out_priority = spq_pkg::PRIO_W'(lvl);
               head_slot[lvl] = (head_slot[lvl] + 1) % spq_pkg::LEVEL_DEPTH;
               held[lvl]--;
            end
         end
         status_hits[e.status]++;
         awaited_rsp.push_back(e);
      endfunction

      function void check_response(spq_pkg::rsp_type got);
         spq_pkg::rsp_type e;
         if (awaited_rsp.size() == 0) begin
            $error("unexpected response: status %0d, out_tag %0h, out_priority %0d",
                   got.status, got.out_tag, got.out_priority);
            mismatches++;
            return;
         end
         e = awaited_rsp.pop_front();
         checked++;
         if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            mismatches++;
         end
         if (got.out_tag !== e.out_tag) begin
            $error("out_tag: expected %0h, actual %0h", e.out_tag, got.out_tag);
            mismatches++;
         end
         if (got.out_priority !== e.out_priority) begin
            $error("out_priority: expected %0d, actual %0d", e.out_priority, got.out_priority);
            mismatches++;
         end
      endfunction

      function int unsigned occupancy();
         int unsigned n;
         n = 0;
         for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
            n += held[i];
         end
         return n;
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   spq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   spq_pkg::rsp_type rsp_data;

   spq_scoreboard board = new();
   int unsigned   req_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;
   int unsigned   rsp_stall_left = 0;
   int unsigned   quiet_cycles = 0;
   int unsigned   sent = 0;

   stable_priority_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offers one request and returns once it has been accepted, possibly idling afterwards.
   task automatic send_request(input logic [spq_pkg::OP_W-1:0] op,
                               input logic [spq_pkg::PRIO_W-1:0] prio,
                               input logic [spq_pkg::TAG_W-1:0] tag);
      spq_pkg::req_type r;
      int unsigned      gap;
      r.op = op;
      r.priority_req = prio;
      r.file_tag = tag;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
      sent++;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: checks each accepted transaction and stalls in random bursts.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_data);
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall_left <= $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Ends the run when no transaction has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned seg_len;
      int unsigned add_pct;
      int unsigned prio_lo;
      int unsigned prio_hi;
      logic [spq_pkg::PRIO_W-1:0] prio;
      logic [spq_pkg::TAG_W-1:0]  tag;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue, extreme levels and tags, one level filled past its depth.
      send_request(spq_pkg::OP_REMOVE, '0, '0);
      send_request(spq_pkg::OP_ADD, '0, '0);
      send_request(spq_pkg::OP_ADD, '1, '1);
      for (int i = 0; i < spq_pkg::LEVEL_DEPTH; i++) begin
         send_request(spq_pkg::OP_ADD, spq_pkg::PRIO_W'(7), spq_pkg::TAG_W'(16'h1000 + i));
      end
      send_request(spq_pkg::OP_ADD, spq_pkg::PRIO_W'(7), 16'hBEEF);
      repeat (3) send_request(spq_pkg::OP_REMOVE, '1, '1);

      // Random segments vary the mix of adds and removes, with wide or narrow
      // priority spreads so that some levels run full.
      while (sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(20, 80);
         case ($urandom_range(0, 3))
            0: add_pct = 25;
            1: add_pct = 50;
            2: add_pct = 75;
            default: add_pct = 95;
         endcase
         if ($urandom_range(0, 1) == 0) begin
            prio_lo = 0;
            prio_hi = spq_pkg::NUM_LEVELS - 1;
         end else begin
            prio_lo = $urandom_range(0, spq_pkg::NUM_LEVELS - 1);
            prio_hi = prio_lo + $urandom_range(0, 2);
            if (prio_hi > spq_pkg::NUM_LEVELS - 1) begin
               prio_hi = spq_pkg::NUM_LEVELS - 1;
            end
         end
         if (sent + CALM_ITEMS >= RANDOM_ITEMS) begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: req_idle_pct = 0;
               1: req_idle_pct = 15;
               default: req_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
               0: rsp_stall_pct = 0;
               1: rsp_stall_pct = 10;
               default: rsp_stall_pct = 30;
            endcase
         end
         for (int i = 0; i < seg_len; i++) begin
            prio = spq_pkg::PRIO_W'($urandom_range(prio_lo, prio_hi));
            tag = spq_pkg::TAG_W'($urandom());
            if ($urandom_range(0, 99) < add_pct) begin
               send_request(spq_pkg::OP_ADD, prio, tag);
            end else begin
               send_request(spq_pkg::OP_REMOVE, prio, tag);
            end
         end
      end
      req_valid <= 1'b0;

      while (board.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses, %0d tags left queued.",
               sent, board.checked, board.occupancy());
      $display("Responses seen: %0d added, %0d removed, %0d empty, %0d full.",
               board.status_hits[spq_pkg::ST_ADDED], board.status_hits[spq_pkg::ST_REMOVED],
               board.status_hits[spq_pkg::ST_EMPTY], board.status_hits[spq_pkg::ST_FULL]);
      if (board.mismatches == 0 && board.awaited_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
